// File: rtl/rdt_pkg.sv
package rdt_pkg;

  localparam int unsigned ENTRIES_DEF = 8;
  localparam int unsigned MAX_RANGE_W = 11;
  localparam int unsigned HOLD_W      = 7;
  localparam int unsigned DELAY_W     = 7;
  localparam int unsigned ID_W        = 16;
  localparam int unsigned SEQ_W       = 8;
  localparam int unsigned DIST_W      = 12;
  localparam int unsigned SLOT_W      = 3;
  localparam int unsigned COUNT_W     = 4;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 11;
  localparam int unsigned TDATA_W     = 40;
  localparam int unsigned TUSER_W     = 2;

  localparam logic [MAX_RANGE_W-1:0] MAX_RANGE_RST = 11'd300;
  localparam logic [HOLD_W-1:0]      HOLD_RST      = 7'd10;

  // Division by ten as a multiplication by 3277 / 2^15; exact for 11-bit operands.
  localparam int unsigned             RECIP_W     = 12;
  localparam logic [RECIP_W-1:0]      RECIP_TEN   = 12'd3277;
  localparam int unsigned             RECIP_SHIFT = 15;
  localparam logic [DELAY_W-1:0]      DELAY_SAT   = 7'd127;

  typedef enum logic [1:0] {
    FUNC_INSERT  = 2'd0,
    FUNC_FORWARD = 2'd1,
    FUNC_TICK    = 2'd2,
    FUNC_ECHO    = 2'd3
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_RANGE = 1'd0,
    REG_HOLD      = 1'd1
  } cfg_reg_e;

  typedef struct packed {
    logic               sent;
    logic [DELAY_W-1:0] delay;
    logic [ID_W-1:0]    id;
    logic [SEQ_W-1:0]   seq;
  } entry_t;

  typedef struct packed {
    logic [3:0]        pad;
    logic [DIST_W-1:0] distance;
    logic [SEQ_W-1:0]  seq_num;
    logic [ID_W-1:0]   packet_id;
  } in_data_t;

  typedef struct packed {
    logic [5:0]         pad;
    logic [COUNT_W-1:0] valid_count;
    logic               echo_matched;
    logic [SEQ_W-1:0]   out_seq;
    logic [ID_W-1:0]    out_id;
    logic [SLOT_W-1:0]  slot;
    logic               sent;
    logic               accepted;
  } out_data_t;

endpackage

// File: rtl/rdt_delay_calc.sv
module rdt_delay_calc (
  input  logic [rdt_pkg::MAX_RANGE_W-1:0] diff_i,
  output logic [rdt_pkg::DELAY_W-1:0]     delay_o
);

  localparam int unsigned ProdW = rdt_pkg::MAX_RANGE_W + rdt_pkg::RECIP_W;

  logic [ProdW-1:0] prod;
  logic [ProdW-rdt_pkg::RECIP_SHIFT-1:0] quot;

  assign prod = ProdW'(diff_i) * ProdW'(rdt_pkg::RECIP_TEN);
  assign quot = prod[ProdW-1:rdt_pkg::RECIP_SHIFT];

  always_comb begin
    if (quot > ($bits(quot))'(rdt_pkg::DELAY_SAT)) begin
      delay_o = rdt_pkg::DELAY_SAT;
    end else begin
      delay_o = quot[rdt_pkg::DELAY_W-1:0];
    end
  end

endmodule

// File: rtl/rebroadcast_delay_table.sv
// The block takes one input transfer at a time and accepts no new one until its
// result is committed; the scan reads the entry memory once per entry over its
// single read port, then commits at most one write.
// The result register lets the next input transfer happen while a result waits.
// Reset clears the valid bits, the entry count and the result valid flag and loads
// max_range = 300 and hold_after_send = 10; the entry memory itself is not cleared.
module rebroadcast_delay_table #(
  parameter int unsigned ENTRIES = rdt_pkg::ENTRIES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // packet_id [15:0], seq_num [23:16], distance [35:24], zero fill above.
  input  logic [rdt_pkg::TDATA_W-1:0]      s_axis_tdata,
  // func [1:0].
  input  logic [rdt_pkg::TUSER_W-1:0]      s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // accepted [0], sent [1], slot [4:2], out_id [20:5], out_seq [28:21],
  // echo_matched [29], valid_count [33:30], zero fill above.
  output logic [rdt_pkg::TDATA_W-1:0]      m_axis_tdata,
  input  logic                             cfg_we_i,
  input  logic [rdt_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [rdt_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int unsigned IdxW = $clog2(ENTRIES);
  localparam int unsigned CntW = $clog2(ENTRIES + 1);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_DRAIN  = 4'b0100,
    S_COMMIT = 4'b1000
  } state_e;

  state_e                             state_q, state_d;
  rdt_pkg::func_e                     func_q, func_d;
  logic [rdt_pkg::ID_W-1:0]           id_q, id_d;
  logic [rdt_pkg::SEQ_W-1:0]          seq_q, seq_d;
  logic [rdt_pkg::MAX_RANGE_W-1:0]    diff_q, diff_d;
  logic [IdxW-1:0]                    idx_q, idx_d;
  logic                               rv_q, rv_d;
  logic [IdxW-1:0]                    ri_q, ri_d;
  logic                               hit_q, hit_d;
  logic [IdxW-1:0]                    hit_idx_q, hit_idx_d;
  rdt_pkg::entry_t                    hit_word_q, hit_word_d;
  logic                               free_q, free_d;
  logic [IdxW-1:0]                    free_idx_q, free_idx_d;
  logic [ENTRIES-1:0]                 valid_q, valid_d;
  logic [CntW-1:0]                    cnt_q, cnt_d;
  logic                               out_valid_q, out_valid_d;
  rdt_pkg::out_data_t                 out_data_q, out_data_d;
  logic [rdt_pkg::MAX_RANGE_W-1:0]    max_range_q;
  logic [rdt_pkg::HOLD_W-1:0]         hold_q;

  rdt_pkg::entry_t                    mem [ENTRIES];
  rdt_pkg::entry_t                    rdata_q;
  logic                               mem_re;
  logic                               mem_we;
  logic [IdxW-1:0]                    mem_waddr;
  rdt_pkg::entry_t                    mem_wdata;

  rdt_pkg::in_data_t                  in_data;
  logic [rdt_pkg::MAX_RANGE_W-1:0]    dist_clamped;
  logic [rdt_pkg::DELAY_W-1:0]        new_delay;
  logic                               rd_v;
  logic                               rd_match;
  logic [rdt_pkg::DELAY_W-1:0]        tick_delay;
  logic [IdxW+2:0]                    slot_ext;
  logic [CntW+3:0]                    cnt_ext;

  assign in_data = rdt_pkg::in_data_t'(s_axis_tdata);

  always_comb begin
    if (in_data.distance > rdt_pkg::DIST_W'(max_range_q)) begin
      dist_clamped = max_range_q;
    end else begin
      dist_clamped = in_data.distance[rdt_pkg::MAX_RANGE_W-1:0];
    end
  end

  rdt_delay_calc u_delay_calc (
    .diff_i  (diff_q),
    .delay_o (new_delay)
  );

  assign rd_v       = valid_q[ri_q];
  assign rd_match   = (rdata_q.id == id_q) && (rdata_q.seq == seq_q);
  assign tick_delay = rdata_q.delay - rdt_pkg::DELAY_W'(rdata_q.delay != '0);

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  always_comb begin
    state_d     = state_q;
    func_d      = func_q;
    id_d        = id_q;
    seq_d       = seq_q;
    diff_d      = diff_q;
    idx_d       = idx_q;
    rv_d        = 1'b0;
    ri_d        = ri_q;
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    hit_word_d  = hit_word_q;
    free_d      = free_q;
    free_idx_d  = free_idx_q;
    valid_d     = valid_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    mem_re      = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = ri_q;
    mem_wdata   = rdata_q;
    slot_ext    = '0;
    cnt_ext     = '0;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    if (rv_q) begin
      case (func_q)
        rdt_pkg::FUNC_INSERT: begin
          if (rd_v && rd_match) begin
            hit_d = 1'b1;
          end
          if (!rd_v && !free_q) begin
            free_d     = 1'b1;
            free_idx_d = ri_q;
          end
        end
        rdt_pkg::FUNC_FORWARD: begin
          if (rd_v && !rdata_q.sent && rdata_q.delay == '0 && !hit_q) begin
            hit_d      = 1'b1;
            hit_idx_d  = ri_q;
            hit_word_d = rdata_q;
          end
        end
        rdt_pkg::FUNC_ECHO: begin
          if (rd_v && rd_match && !hit_q) begin
            hit_d      = 1'b1;
            hit_idx_d  = ri_q;
            hit_word_d = rdata_q;
          end
        end
        default: begin
          if (rd_v) begin
            if (tick_delay == '0 && rdata_q.sent) begin
              valid_d[ri_q] = 1'b0;
              cnt_d         = cnt_q - CntW'(1);
            end else begin
              mem_we          = 1'b1;
              mem_wdata.delay = tick_delay;
            end
          end
        end
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          func_d  = rdt_pkg::func_e'(s_axis_tuser);
          id_d    = in_data.packet_id;
          seq_d   = in_data.seq_num;
          diff_d  = max_range_q - dist_clamped;
          idx_d   = '0;
          hit_d   = 1'b0;
          free_d  = 1'b0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        mem_re = 1'b1;
        rv_d   = 1'b1;
        ri_d   = idx_q;
        idx_d  = idx_q + IdxW'(1);
        if (idx_q == IdxW'(ENTRIES - 1)) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_COMMIT;
      end
      S_COMMIT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_data_d = '0;
          case (func_q)
            rdt_pkg::FUNC_INSERT: begin
              if (!hit_q && free_q) begin
                mem_we              = 1'b1;
                mem_waddr           = free_idx_q;
                mem_wdata.sent      = 1'b0;
                mem_wdata.delay     = new_delay;
                mem_wdata.id        = id_q;
                mem_wdata.seq       = seq_q;
                valid_d[free_idx_q] = 1'b1;
                cnt_d               = cnt_q + CntW'(1);
                slot_ext            = {3'b000, free_idx_q};
                out_data_d.accepted = 1'b1;
                out_data_d.slot     = slot_ext[2:0];
              end
            end
            rdt_pkg::FUNC_FORWARD: begin
              if (hit_q) begin
                mem_we             = 1'b1;
                mem_waddr          = hit_idx_q;
                mem_wdata          = hit_word_q;
                mem_wdata.sent     = 1'b1;
                mem_wdata.delay    = hold_q;
                slot_ext           = {3'b000, hit_idx_q};
                out_data_d.sent    = 1'b1;
                out_data_d.slot    = slot_ext[2:0];
                out_data_d.out_id  = hit_word_q.id;
                out_data_d.out_seq = hit_word_q.seq;
              end
            end
            rdt_pkg::FUNC_ECHO: begin
              if (hit_q) begin
                mem_we                  = 1'b1;
                mem_waddr               = hit_idx_q;
                mem_wdata               = hit_word_q;
                mem_wdata.sent          = 1'b1;
                out_data_d.echo_matched = 1'b1;
              end
            end
            default: begin
            end
          endcase
          cnt_ext                = {4'b0000, cnt_d};
          out_data_d.valid_count = cnt_ext[3:0];
          out_valid_d            = 1'b1;
          state_d                = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rv_q        <= 1'b0;
      valid_q     <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      max_range_q <= rdt_pkg::MAX_RANGE_RST;
      hold_q      <= rdt_pkg::HOLD_RST;
    end else begin
      state_q     <= state_d;
      rv_q        <= rv_d;
      valid_q     <= valid_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (rdt_pkg::cfg_reg_e'(cfg_idx_i))
          rdt_pkg::REG_MAX_RANGE: max_range_q <= cfg_data_i;
          rdt_pkg::REG_HOLD:      hold_q      <= cfg_data_i[rdt_pkg::HOLD_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    func_q     <= func_d;
    id_q       <= id_d;
    seq_q      <= seq_d;
    diff_q     <= diff_d;
    idx_q      <= idx_d;
    ri_q       <= ri_d;
    hit_q      <= hit_d;
    hit_idx_q  <= hit_idx_d;
    hit_word_q <= hit_word_d;
    free_q     <= free_d;
    free_idx_q <= free_idx_d;
    out_data_q <= out_data_d;
  end

endmodule

// File: rtl/rdt_checker.sv
module rdt_checker #(
  parameter int unsigned ENTRIES = rdt_pkg::ENTRIES_DEF
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [rdt_pkg::TDATA_W-1:0] m_axis_tdata
);

  rdt_pkg::out_data_t od;

  assign od = rdt_pkg::out_data_t'(m_axis_tdata);

  a_reset_quiet : assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("result offered during reset");

  a_hold_stalled : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_one_outcome : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> $onehot0({od.accepted, od.sent, od.echo_matched}))
    else $error("more than one outcome flag in a result");

  a_unused_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !od.sent |-> od.out_id == '0 && od.out_seq == '0
      && (od.accepted || od.slot == '0))
    else $error("unused result fields not zero");

  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (ENTRIES > 15) || (32'(od.valid_count) <= ENTRIES))
    else $error("valid count exceeds table size");

endmodule

bind rebroadcast_delay_table rdt_checker #(.ENTRIES(ENTRIES)) u_rdt_checker (.*);
